// ===== rtl/mvn_pkg.sv =====
// Shared types, constants and codes for the mesh vertex normal block.
// Has no dependencies. The controller, the datapath and the top level import it.
package mvn_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = 12;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CMP_W        = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    localparam int COORD_W  = 24;
    localparam int POS_W    = 3 * COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CROSS_W  = 51;
    localparam int MAG_W    = 50;
    localparam int NORM_BIT = 30;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 64;
    localparam int SQRT_TOP = PROD_W - 2;
    localparam int ROOT_W   = 32;
    localparam int FRAC_W   = 14;
    localparam int DIVQ_W   = 15;
    localparam int NUM_W    = NORM_BIT + 1 + FRAC_W + 1;
    localparam int NORM_W   = 16;
    localparam int Q_ONE    = 16384;

    localparam int STEP_W         = 5;
    localparam int SEL_W          = 2;
    localparam int MSEL_W         = 4;
    localparam int FETCH_LAST     = 3;
    localparam int CROSS_LAST     = 6;
    localparam int SQUARE_LAST    = 3;
    localparam int SQRT_LAST      = 31;
    localparam int DIV_LAST       = DIVQ_W - 1;
    localparam int UPDATE_LAST    = 5;
    localparam int SUM_FETCH_LAST = 1;

    // Multiplier operand selects: cross-product terms first, then the squares.
    localparam int MS_CROSS0 = 0;
    localparam int MS_SQ0    = 6;

    // Corner selects.
    localparam int SEL_A = 0;
    localparam int SEL_B = 1;
    localparam int SEL_C = 2;

    typedef enum logic [1:0] {
        ACT_VERTEX = 2'd0,
        ACT_FACE   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic [IDX_W-1:0]          index_c;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     zero_length;
    } res_t;

    typedef struct packed {
        logic              load;
        logic              append;
        logic              clear;
        logic              pos_rd;
        logic              pos_cap;
        logic              diff;
        logic              mul;
        logic              acc;
        logic              sum_rd;
        logic              sum_cap;
        logic              mag;
        logic              set_zero;
        logic              shift;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              finish;
        logic              sum_wr;
        logic              reply;
        logic [SEL_W-1:0]  rd_sel;
        logic [SEL_W-1:0]  cap_sel;
        logic [MSEL_W-1:0] mul_sel;
        logic [MSEL_W-1:0] acc_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] status;
        logic       zero;
        logic       aligned;
    } sts_t;

endpackage

// ===== rtl/mvn_ram.sv =====
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Has no dependencies.
module mvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mvn_ctrl.sv =====
// Sequencing state machine for the mesh vertex normal block.
// Depends on mvn_pkg. Drives the datapath by cmd_t and reads back sts_t.
module mvn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mvn_pkg::sts_t sts,
    output mvn_pkg::cmd_t cmd
);
    import mvn_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_DECODE    = 17'h00002,
        S_FETCH     = 17'h00004,
        S_DIFF      = 17'h00008,
        S_CROSS     = 17'h00010,
        S_SUM_FETCH = 17'h00020,
        S_MAG       = 17'h00040,
        S_CHECK     = 17'h00080,
        S_NORM      = 17'h00100,
        S_SQUARE    = 17'h00200,
        S_SQRT_INIT = 17'h00400,
        S_SQRT      = 17'h00800,
        S_DIV_INIT  = 17'h01000,
        S_DIV       = 17'h02000,
        S_FINISH    = 17'h04000,
        S_UPDATE    = 17'h08000,
        S_REPLY     = 17'h10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] step_prev;

    assign step_prev = step_reg - STEP_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                step_next = '0;
                if (sts.status != ST_OK)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    case (sts.action)
                        ACT_VERTEX:
                        begin
                            cmd.append = 1'b1;
                            state_next = S_REPLY;
                        end
                        ACT_FACE:  state_next = S_FETCH;
                        ACT_READ:  state_next = S_SUM_FETCH;
                        ACT_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_REPLY;
                        end
                        default:   state_next = S_REPLY;
                    endcase
                end
            end
            S_FETCH:
            begin
                // Read one corner per cycle and capture the one read before.
                if (step_reg < STEP_W'(FETCH_LAST))
                begin
                    cmd.pos_rd = 1'b1;
                    cmd.rd_sel = step_reg[SEL_W-1:0];
                end
                if (step_reg != '0)
                begin
                    cmd.pos_cap = 1'b1;
                    cmd.cap_sel = step_prev[SEL_W-1:0];
                end
                if (step_reg == STEP_W'(FETCH_LAST))
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                step_next  = '0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                if (step_reg < STEP_W'(CROSS_LAST))
                begin
                    cmd.mul     = 1'b1;
                    cmd.mul_sel = MSEL_W'(MS_CROSS0) + step_reg[MSEL_W-1:0];
                end
                if (step_reg != '0)
                begin
                    cmd.acc     = 1'b1;
                    cmd.acc_sel = MSEL_W'(MS_CROSS0) + step_prev[MSEL_W-1:0];
                end
                if (step_reg == STEP_W'(CROSS_LAST))
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_SUM_FETCH:
            begin
                if (step_reg == '0)
                begin
                    cmd.sum_rd = 1'b1;
                    cmd.rd_sel = SEL_W'(SEL_A);
                end
                else
                begin
                    cmd.sum_cap = 1'b1;
                end
                if (step_reg == STEP_W'(SUM_FETCH_LAST))
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.zero)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = S_REPLY;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                step_next = '0;
                if (sts.aligned)
                begin
                    state_next = S_SQUARE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_SQUARE:
            begin
                if (step_reg < STEP_W'(SQUARE_LAST))
                begin
                    cmd.mul     = 1'b1;
                    cmd.mul_sel = MSEL_W'(MS_SQ0) + step_reg[MSEL_W-1:0];
                end
                if (step_reg != '0)
                begin
                    cmd.acc     = 1'b1;
                    cmd.acc_sel = MSEL_W'(MS_SQ0) + step_prev[MSEL_W-1:0];
                end
                if (step_reg == STEP_W'(SQUARE_LAST))
                begin
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == STEP_W'(SQRT_LAST))
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_LAST))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                step_next  = '0;
                state_next = (sts.action == ACT_FACE) ? S_UPDATE : S_REPLY;
            end
            S_UPDATE:
            begin
                // Read-modify-write of each corner's sum, one corner at a time.
                if (!step_reg[0])
                begin
                    cmd.sum_rd = 1'b1;
                    cmd.rd_sel = step_reg[SEL_W:1];
                end
                else
                begin
                    cmd.sum_wr  = 1'b1;
                    cmd.cap_sel = step_reg[SEL_W:1];
                end
                if (step_reg == STEP_W'(UPDATE_LAST))
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_REPLY:
            begin
                cmd.reply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/mvn_datapath.sv =====
// Datapath of the mesh vertex normal block: vertex and sum stores, one shared multiplier,
// the normalizing shifter, the square root and three dividers. Depends on mvn_pkg, mvn_ram.
module mvn_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  mvn_pkg::req_t request,
    input  mvn_pkg::cmd_t cmd,
    output mvn_pkg::sts_t sts,
    output logic          done,
    output mvn_pkg::res_t result
);
    import mvn_pkg::*;

    req_t                      req_reg;
    logic [1:0]                status_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [1:0]                st_load;
    logic [CMP_W-1:0]          cnt_cmp;
    logic [CMP_W-1:0]          ia_w, ib_w, ic_w;
    logic [CMP_W-1:0]          rd_idx, wr_idx;

    logic [POS_W-1:0]          pos_rdata, sum_rdata, sum_wdata, sat_data;
    logic                      sum_we;
    logic [ADDR_W-1:0]         sum_waddr;

    logic signed [COORD_W-1:0] px_reg [3];
    logic signed [COORD_W-1:0] py_reg [3];
    logic signed [COORD_W-1:0] pz_reg [3];
    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] full_prod;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [CROSS_W-1:0] c_reg [3];
    logic signed [CROSS_W-1:0] c_neg [3];
    logic [PROD_W-1:0]         s_reg;

    logic [MAG_W-1:0]          m_reg [3];
    logic [2:0]                neg_reg;
    logic [MAG_W-1:0]          m_or;
    logic                      near_zero;
    logic [3:0]                sq_sum;
    logic [3:0]                sq_lim;

    logic [PROD_W-1:0]         x_reg, root_reg, bit_reg, trial;
    logic [ROOT_W-1:0]         len_reg;
    logic [ROOT_W-1:0]         rem_reg [3];
    logic [DIVQ_W-1:0]         low_reg [3];
    logic [DIVQ_W-1:0]         q_reg [3];
    logic [NUM_W-1:0]          num [3];
    logic [ROOT_W:0]           dtry [3];
    logic [DIVQ_W-1:0]         qc [3];

    logic signed [NORM_W-1:0]  n_reg [3];
    logic                      zero_reg;
    logic signed [COORD_W-1:0] sum_f [3];
    logic signed [COORD_W:0]   sum_s [3];

    logic                      done_reg;
    res_t                      result_reg;

    // Status of a request, judged against the vertex count at acceptance.
    always_comb
    begin
        cnt_cmp = CMP_W'(count_reg);
        st_load = ST_OK;
        case (request.action)
            ACT_VERTEX:
            begin
                if (count_reg == CNT_W'(MAX_VERTICES))
                begin
                    st_load = ST_FULL;
                end
            end
            ACT_FACE:
            begin
                if (CMP_W'(request.index_a) >= cnt_cmp || CMP_W'(request.index_b) >= cnt_cmp ||
                    CMP_W'(request.index_c) >= cnt_cmp)
                begin
                    st_load = ST_RANGE;
                end
            end
            ACT_READ:
            begin
                if (CMP_W'(request.index_a) >= cnt_cmp)
                begin
                    st_load = ST_RANGE;
                end
            end
            default: st_load = ST_OK;
        endcase
    end

    assign ia_w = CMP_W'(req_reg.index_a);
    assign ib_w = CMP_W'(req_reg.index_b);
    assign ic_w = CMP_W'(req_reg.index_c);

    always_comb
    begin
        case (cmd.rd_sel)
            SEL_W'(SEL_B): rd_idx = ib_w;
            SEL_W'(SEL_C): rd_idx = ic_w;
            default:       rd_idx = ia_w;
        endcase
        case (cmd.cap_sel)
            SEL_W'(SEL_B): wr_idx = ib_w;
            SEL_W'(SEL_C): wr_idx = ic_w;
            default:       wr_idx = ia_w;
        endcase
    end

    mvn_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({req_reg.coord_x, req_reg.coord_y, req_reg.coord_z}),
        .re    (cmd.pos_rd),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (pos_rdata)
    );

    // Saturating add of the face normal into the sum just read.
    always_comb
    begin
        sum_f[0] = sum_rdata[POS_W-1 -: COORD_W];
        sum_f[1] = sum_rdata[2*COORD_W-1 -: COORD_W];
        sum_f[2] = sum_rdata[COORD_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            sum_s[i] = (COORD_W+1)'(sum_f[i]) + (COORD_W+1)'(n_reg[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (sum_s[i][COORD_W] != sum_s[i][COORD_W-1])
            begin
                sat_data[(2-i)*COORD_W +: COORD_W] =
                    sum_s[i][COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
            end
            else
            begin
                sat_data[(2-i)*COORD_W +: COORD_W] = sum_s[i][COORD_W-1:0];
            end
        end
    end

    assign sum_we    = cmd.append | cmd.sum_wr;
    assign sum_waddr = cmd.append ? count_reg[ADDR_W-1:0] : wr_idx[ADDR_W-1:0];
    assign sum_wdata = cmd.append ? '0 : sat_data;

    mvn_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (cmd.sum_rd),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (sum_rdata)
    );

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_W'(0): begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[2]); end
            MSEL_W'(1): begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[1]); end
            MSEL_W'(2): begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[0]); end
            MSEL_W'(3): begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[2]); end
            MSEL_W'(4): begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[1]); end
            MSEL_W'(5): begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[0]); end
            MSEL_W'(6):
            begin
                mul_a = {2'b00, m_reg[0][NORM_BIT:0]};
                mul_b = {2'b00, m_reg[0][NORM_BIT:0]};
            end
            MSEL_W'(7):
            begin
                mul_a = {2'b00, m_reg[1][NORM_BIT:0]};
                mul_b = {2'b00, m_reg[1][NORM_BIT:0]};
            end
            MSEL_W'(8):
            begin
                mul_a = {2'b00, m_reg[2][NORM_BIT:0]};
                mul_b = {2'b00, m_reg[2][NORM_BIT:0]};
            end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign full_prod = mul_a * mul_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_neg[i] = -c_reg[i];
        end
    end

    // Zero-length test on the magnitudes, and the alignment test for the shifter.
    always_comb
    begin
        m_or      = m_reg[0] | m_reg[1] | m_reg[2];
        near_zero = 1'b1;
        sq_sum    = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (m_reg[i][MAG_W-1:2] != '0 || m_reg[i][1:0] == 2'd3)
            begin
                near_zero = 1'b0;
            end
            sq_sum = sq_sum + ((m_reg[i][1:0] == 2'd2) ? 4'd4 : {3'd0, m_reg[i][0]});
        end
        sq_lim = (req_reg.action == ACT_FACE) ? 4'd4 : 4'd0;
    end

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i]  = NUM_W'({m_reg[i][NORM_BIT:0], {FRAC_W{1'b0}}}) + NUM_W'(root_reg[ROOT_W-1:1]);
            dtry[i] = {rem_reg[i], low_reg[i][DIVQ_W-1]};
            qc[i]   = (q_reg[i] > DIVQ_W'(Q_ONE)) ? DIVQ_W'(Q_ONE) : q_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= request;
            status_reg <= st_load;
            zero_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= '0;
            end
        end
        if (cmd.pos_cap)
        begin
            case (cmd.cap_sel)
                SEL_W'(SEL_B):
                begin
                    px_reg[1] <= pos_rdata[POS_W-1 -: COORD_W];
                    py_reg[1] <= pos_rdata[2*COORD_W-1 -: COORD_W];
                    pz_reg[1] <= pos_rdata[COORD_W-1:0];
                end
                SEL_W'(SEL_C):
                begin
                    px_reg[2] <= pos_rdata[POS_W-1 -: COORD_W];
                    py_reg[2] <= pos_rdata[2*COORD_W-1 -: COORD_W];
                    pz_reg[2] <= pos_rdata[COORD_W-1:0];
                end
                default:
                begin
                    px_reg[0] <= pos_rdata[POS_W-1 -: COORD_W];
                    py_reg[0] <= pos_rdata[2*COORD_W-1 -: COORD_W];
                    pz_reg[0] <= pos_rdata[COORD_W-1:0];
                end
            endcase
        end
        if (cmd.diff)
        begin
            u_reg[0] <= DIFF_W'(px_reg[1]) - DIFF_W'(px_reg[0]);
            u_reg[1] <= DIFF_W'(py_reg[1]) - DIFF_W'(py_reg[0]);
            u_reg[2] <= DIFF_W'(pz_reg[1]) - DIFF_W'(pz_reg[0]);
            v_reg[0] <= DIFF_W'(px_reg[2]) - DIFF_W'(px_reg[0]);
            v_reg[1] <= DIFF_W'(py_reg[2]) - DIFF_W'(py_reg[0]);
            v_reg[2] <= DIFF_W'(pz_reg[2]) - DIFF_W'(pz_reg[0]);
        end
        if (cmd.mul)
        begin
            prod_reg <= full_prod[PROD_W-1:0];
        end
        if (cmd.acc)
        begin
            case (cmd.acc_sel)
                MSEL_W'(0): c_reg[0] <= prod_reg[CROSS_W-1:0];
                MSEL_W'(1): c_reg[0] <= c_reg[0] - prod_reg[CROSS_W-1:0];
                MSEL_W'(2): c_reg[1] <= prod_reg[CROSS_W-1:0];
                MSEL_W'(3): c_reg[1] <= c_reg[1] - prod_reg[CROSS_W-1:0];
                MSEL_W'(4): c_reg[2] <= prod_reg[CROSS_W-1:0];
                MSEL_W'(5): c_reg[2] <= c_reg[2] - prod_reg[CROSS_W-1:0];
                MSEL_W'(6): s_reg    <= prod_reg;
                default:    s_reg    <= s_reg + prod_reg;
            endcase
        end
        if (cmd.sum_cap)
        begin
            c_reg[0] <= CROSS_W'(sum_f[0]);
            c_reg[1] <= CROSS_W'(sum_f[1]);
            c_reg[2] <= CROSS_W'(sum_f[2]);
        end
        if (cmd.mag)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= c_reg[i][CROSS_W-1];
                m_reg[i]   <= c_reg[i][CROSS_W-1] ? c_neg[i][MAG_W-1:0] : c_reg[i][MAG_W-1:0];
            end
        end
        if (cmd.set_zero)
        begin
            zero_reg <= 1'b1;
        end
        if (cmd.shift)
        begin
            // Right shifts truncate; left shifts are exact.
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= (m_or[MAG_W-1:NORM_BIT+1] != '0) ? (m_reg[i] >> 1) : (m_reg[i] << 1);
            end
        end
        if (cmd.sqrt_init)
        begin
            x_reg    <= s_reg;
            root_reg <= '0;
            bit_reg  <= PROD_W'(1) << SQRT_TOP;
        end
        if (cmd.sqrt_step)
        begin
            if (x_reg >= trial)
            begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            len_reg <= root_reg[ROOT_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= ROOT_W'(num[i][NUM_W-1:DIVQ_W]);
                low_reg[i] <= num[i][DIVQ_W-1:0];
                q_reg[i]   <= '0;
            end
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dtry[i] >= {1'b0, len_reg})
                begin
                    rem_reg[i] <= ROOT_W'(dtry[i] - {1'b0, len_reg});
                    q_reg[i]   <= {q_reg[i][DIVQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= dtry[i][ROOT_W-1:0];
                    q_reg[i]   <= {q_reg[i][DIVQ_W-2:0], 1'b0};
                end
                low_reg[i] <= low_reg[i] << 1;
            end
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= neg_reg[i] ? -NORM_W'(qc[i]) : NORM_W'(qc[i]);
            end
        end
        if (cmd.reply)
        begin
            result_reg.status      <= status_reg;
            result_reg.normal_x    <= n_reg[0];
            result_reg.normal_y    <= n_reg[1];
            result_reg.normal_z    <= n_reg[2];
            result_reg.zero_length <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign sts.action  = req_reg.action;
    assign sts.status  = status_reg;
    assign sts.zero    = near_zero && (sq_sum <= sq_lim);
    assign sts.aligned = m_or[NORM_BIT] && (m_or[MAG_W-1:NORM_BIT+1] == '0);

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_wr |-> $past(cmd.sum_rd))
        else $error("sum written without a read the cycle before");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (root_reg[ROOT_W-1:NORM_BIT] != '0))
        else $error("vector length below the normalized range");
`endif

endmodule

// ===== rtl/mesh_vertex_normals.sv =====
// Mesh vertex normals: one request at a time. Add vertex, clear and any range or full error
// go from decode straight to the reply; a face and a read run through the magnitude check,
// and on to the square root and divide unless the check finds zero length. The normalizing
// shifter moves one bit per cycle, ahead of the 32-step square root and the 15-step divide.
// busy stays high until done rises; a new request can be accepted at the edge that ends the
// done cycle. Reset clears the vertex count, the done flag and the controller only.
module mesh_vertex_normals (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mvn_pkg::req_t request,
    output logic          done,
    output mvn_pkg::res_t result
);
    import mvn_pkg::*;

    // The controller steps the datapath through fetch, cross product, normalization,
    // square root, divide and sum update; the datapath reports back through sts.
    cmd_t cmd;
    sts_t sts;

    mvn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // A request is taken when start is high and busy is low; the datapath captures it then.
    // The result is valid for one cycle while done is high; the receiver cannot stall it.
    mvn_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule
